### rtl/core/bddq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bddq_pkg;

  localparam logic [1:0] KIND_ADD_HEAD = 2'd0;
  localparam logic [1:0] KIND_ADD_TAIL = 2'd1;
  localparam logic [1:0] KIND_DELETE   = 2'd2;
  localparam logic [1:0] KIND_POP      = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [6:0]         repeat_req;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped;
    logic signed [31:0] top_value;
    logic [6:0]         count;
    logic               is_empty;
    logic [6:0]         removed;
  } result_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

endpackage

`default_nettype wire

### rtl/core/bddq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bddq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 7,
  parameter int IDX        = 0
) (
  input  wire                    clk,
  input  wire bddq_pkg::cell_op_t op,
  input  wire [CW-1:0]           count,
  input  wire [DATA_WIDTH-1:0]   din,
  input  wire [DATA_WIDTH-1:0]   left,
  input  wire [DATA_WIDTH-1:0]   right,
  input  wire                    above_in,
  output logic [DATA_WIDTH-1:0]  data,
  output logic                   above_out
);

  logic live;
  logic hit;

  assign live      = CW'(IDX) < count;
  assign hit       = live && (data == din);
  assign above_out = above_in | hit;

  always_ff @(posedge clk) begin
    unique case (op)
      bddq_pkg::CELL_HOLD: data <= data;
      bddq_pkg::CELL_PUSH: data <= left;
      bddq_pkg::CELL_POP:  data <= right;
      bddq_pkg::CELL_INS: begin
        if (CW'(IDX) == count) data <= din;
      end
      bddq_pkg::CELL_DEL: begin
        if (!above_in) data <= right;
      end
      default: data <= data;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bounded_deque_delete_by_value_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque / stack with delete by value.
// Channels: an item on "item" is taken at a clock edge where start is high
// and busy is low. Each item gives one result on "result", marked by done
// for exactly one cycle; the receiver cannot hold it off.
// Storage is a row of DEPTH cells, cell 0 holding the tail (top) entry and
// higher cells holding entries toward the head. Every cell compares and
// shifts in the same cycle.
// Flow: add at head, add at tail and pop are applied at the accepting
// edge, where done is also registered; busy stays low, so one such item
// can be taken every cycle. A delete with a nonzero repeat_req on a
// non-empty store makes match attempts in turn, removing one entry per
// hit, until repeat_req entries are gone or an attempt finds no match,
// then done follows; busy is high meanwhile. The per-attempt path is the
// DATA_WIDTH-bit equality compare per cell and the chain down to cell 0.
// Reset: count goes to zero and the block is idle; cell contents are not
// cleared and are never read below the count.
module bounded_deque_delete_by_value_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire bddq_pkg::item_t item,
  output logic               busy,
  output logic               done,
  output bddq_pkg::result_t  result
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DEL
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [DATA_WIDTH-1:0]   key;
  logic [6:0]              reps;
  logic [6:0]              removed;
  logic [1:0]              status;
  logic [31:0]             popped;

  logic [DATA_WIDTH-1:0]   din_conv;
  logic [DATA_WIDTH-1:0]   din;
  logic [31:0]             top32;
  logic                    found;
  logic                    full;
  logic [6:0]              removed_inc;
  bddq_pkg::cell_op_t      op;

  logic [DATA_WIDTH-1:0]   cell_data [DEPTH];
  logic [DEPTH-1:0]        above;

  always_comb begin
    for (int b = 0; b < DATA_WIDTH; b++) begin
      din_conv[b] = item.value[(b < 32) ? b : 31];
    end
    for (int b = 0; b < 32; b++) begin
      top32[b] = cell_data[0][(b < DATA_WIDTH) ? b : DATA_WIDTH - 1];
    end
  end

  assign full        = (count == CW'(DEPTH));
  assign found       = above[0];
  assign removed_inc = removed + 7'd1;
  assign busy        = (state == ST_DEL);

  always_comb begin
    op  = bddq_pkg::CELL_HOLD;
    din = din_conv;
    if (state == ST_DEL) begin
      din = key;
      if (found) op = bddq_pkg::CELL_DEL;
    end else if (start) begin
      unique case (item.kind)
        bddq_pkg::KIND_ADD_HEAD: begin
          if (!full) op = bddq_pkg::CELL_INS;
        end
        bddq_pkg::KIND_ADD_TAIL: begin
          if (!full) op = bddq_pkg::CELL_PUSH;
        end
        bddq_pkg::KIND_DELETE: op = bddq_pkg::CELL_HOLD;
        bddq_pkg::KIND_POP: begin
          if (count != '0) op = bddq_pkg::CELL_POP;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    logic                  above_in;

    if (g == 0) begin : g_first
      assign left_d = din;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d  = cell_data[g];
      assign above_in = 1'b0;
    end else begin : g_mid_r
      assign right_d  = cell_data[g+1];
      assign above_in = above[g+1];
    end

    bddq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .IDX        (g)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count),
      .din       (din),
      .left      (left_d),
      .right     (right_d),
      .above_in  (above_in),
      .data      (cell_data[g]),
      .above_out (above[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            status  <= bddq_pkg::STAT_OK;
            popped  <= '0;
            removed <= '0;
            unique case (item.kind)
              bddq_pkg::KIND_ADD_HEAD, bddq_pkg::KIND_ADD_TAIL: begin
                if (full) status <= bddq_pkg::STAT_FULL;
                else count <= count + CW'(1);
                done <= 1'b1;
              end
              bddq_pkg::KIND_POP: begin
                if (count == '0) begin
                  status <= bddq_pkg::STAT_EMPTY;
                end else begin
                  count  <= count - CW'(1);
                  popped <= top32;
                end
                done <= 1'b1;
              end
              bddq_pkg::KIND_DELETE: begin
                if (item.repeat_req == '0) begin
                  done <= 1'b1;
                end else if (count == '0) begin
                  status <= bddq_pkg::STAT_EMPTY;
                  done   <= 1'b1;
                end else begin
                  key   <= din_conv;
                  reps  <= item.repeat_req;
                  state <= ST_DEL;
                end
              end
            endcase
          end
        end
        ST_DEL: begin
          if (found) begin
            count   <= count - CW'(1);
            removed <= removed_inc;
            if (removed_inc == reps) begin
              status <= bddq_pkg::STAT_OK;
              done   <= 1'b1;
              state  <= ST_IDLE;
            end
          end else begin
            status <= (removed != '0) ? bddq_pkg::STAT_OK : bddq_pkg::STAT_NOT_FOUND;
            done   <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    result.status    = status;
    result.popped    = popped;
    result.top_value = (count == '0) ? '0 : top32;
    result.count     = 7'(count);
    result.is_empty  = (count == '0);
    result.removed   = removed;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while delete still running");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.kind == bddq_pkg::KIND_ADD_TAIL && !full
    |=> count == $past(count) + CW'(1))
    else $error("push did not grow count");

  a_del_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEL && found |=> count == $past(count) - CW'(1))
    else $error("delete match did not shrink count");

  a_del_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEL |-> removed < reps)
    else $error("delete ran past its repeat count");

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bddq_pkg::*;

  localparam int CAPACITY = 64;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  logic signed [31:0] mirror_entries[$];
  result_t            outcomes_due[$];
  logic signed [31:0] value_pool[8];
  int                 fail_count = 0;

  bounded_deque_delete_by_value_core #(
    .DEPTH(CAPACITY),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic result_t apply_item(item_t it);
    result_t r;
    int      hit;
    r = '0;
    case (it.kind)
      KIND_ADD_HEAD, KIND_ADD_TAIL: begin
        if (mirror_entries.size() >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (it.kind == KIND_ADD_HEAD) begin
          mirror_entries.push_front(it.value);
        end else begin
          mirror_entries.push_back(it.value);
        end
      end
      KIND_DELETE: begin
        if (it.repeat_req != 0) begin
          if (mirror_entries.size() == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            for (int n = 0; n < it.repeat_req; n++) begin
              hit = -1;
              for (int i = 0; i < mirror_entries.size(); i++) begin
                if (mirror_entries[i] == it.value) begin
                  hit = i;
                  break;
                end
              end
              if (hit < 0) break;
              mirror_entries.delete(hit);
              r.removed++;
            end
            r.status = (r.removed != 0) ? STAT_OK : STAT_NOT_FOUND;
          end
        end
      end
      default: begin
        if (mirror_entries.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = mirror_entries.pop_back();
        end
      end
    endcase
    r.count     = 7'(mirror_entries.size());
    r.is_empty  = (mirror_entries.size() == 0);
    r.top_value = (mirror_entries.size() != 0) ? mirror_entries[$] : 32'sd0;
    return r;
  endfunction

  function automatic item_t make_item(logic [1:0] k, logic signed [31:0] v, logic [6:0] n);
    item_t it;
    it.kind       = k;
    it.value      = v;
    it.repeat_req = n;
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        $error("result with no item pending: %p", result);
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("status", want.status, result.status);
        check_field("popped", want.popped, result.popped);
        check_field("top_value", want.top_value, result.top_value);
        check_field("count", want.count, result.count);
        check_field("is_empty", want.is_empty, result.is_empty);
        check_field("removed", want.removed, result.removed);
      end
    end
  end

  // Call at a falling edge; return at a falling edge with start still high.
  task automatic send_item(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    outcomes_due.push_back(apply_item(it));
    @(negedge clk);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      item  <= make_item(2'($urandom), $urandom, 7'($urandom));
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (outcomes_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom;
    return value_pool[$urandom_range(7)];
  endfunction

  function automatic logic [6:0] pick_repeat();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(64));
      default: return 7'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic item_t random_item(int add_pct, int del_pct);
    int         roll;
    logic [1:0] k;
    roll = $urandom_range(99);
    if (roll < add_pct) begin
      k = $urandom_range(1) ? KIND_ADD_TAIL : KIND_ADD_HEAD;
    end else if (roll < add_pct + del_pct) begin
      k = KIND_DELETE;
    end else begin
      k = KIND_POP;
    end
    return make_item(k, pick_value(), (k == KIND_DELETE) ? pick_repeat()
                                                          : 7'($urandom_range(64)));
  endfunction

  task automatic test_empty_store();
    send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    send_item(make_item(KIND_DELETE, 32'sd5, 7'd1));
    send_item(make_item(KIND_DELETE, 32'sd5, 7'd0));
    send_item(make_item(KIND_DELETE, -32'sd1, 7'd64));
    wait_drained();
  endtask

  task automatic test_extremes();
    send_item(make_item(KIND_ADD_TAIL, 32'sh7fffffff, 7'd0));
    send_item(make_item(KIND_ADD_HEAD, 32'sh80000000, 7'd127));
    send_item(make_item(KIND_ADD_TAIL, -32'sd1, 7'd0));
    send_item(make_item(KIND_ADD_HEAD, 32'sd0, 7'd0));
    send_item(make_item(KIND_DELETE, 32'sd0, 7'd0));
    send_item(make_item(KIND_DELETE, 32'sd12345, 7'd1));
    send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    send_item(make_item(KIND_DELETE, 32'sh80000000, 7'd64));
    send_item(make_item(KIND_DELETE, 32'sd0, 7'd63));
    pause(3);
    send_item(make_item(KIND_ADD_TAIL, 32'sd42, 7'd0));
    send_item(make_item(KIND_DELETE, 32'sd43, 7'd1));
    send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    send_item(make_item(KIND_ADD_TAIL, 32'sd3, 7'd0));
    send_item(make_item(KIND_ADD_TAIL, 32'sd3, 7'd0));
    send_item(make_item(KIND_ADD_TAIL, 32'sd9, 7'd0));
    send_item(make_item(KIND_ADD_HEAD, 32'sd3, 7'd0));
    send_item(make_item(KIND_DELETE, 32'sd3, 7'd5));
    send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    wait_drained();
  endtask

  task automatic test_full_store();
    for (int i = 0; i < CAPACITY; i++) begin
      send_item(make_item($urandom_range(1) ? KIND_ADD_TAIL : KIND_ADD_HEAD,
                          value_pool[$urandom_range(3)], 7'd0));
      if ($urandom_range(7) == 0) pause($urandom_range(1, 4));
    end
    send_item(make_item(KIND_ADD_HEAD, 32'sd77, 7'd0));
    send_item(make_item(KIND_ADD_TAIL, 32'sd78, 7'd0));
    send_item(make_item(KIND_DELETE, value_pool[0], 7'd64));
    send_item(make_item(KIND_DELETE, value_pool[1], 7'd2));
    while (mirror_entries.size() > 8) begin
      send_item(make_item(KIND_POP, 32'sd0, 7'd0));
    end
    send_item(make_item(KIND_DELETE, value_pool[2], 7'd64));
    send_item(make_item(KIND_DELETE, value_pool[3], 7'd64));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int add_pct;
    int del_pct;
    int burst_left;
    bit gaps_on;
    burst_left = 0;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 3)
        0: begin add_pct = 75; del_pct = 15; end
        1: begin add_pct = 10; del_pct = 50; end
        default: begin add_pct = 45; del_pct = 30; end
      endcase
      gaps_on = (phase % 4) != 3;
      value_pool[$urandom_range(7)] = $urandom;
      for (int n = 0; n < 38; n++) begin
        if (gaps_on && burst_left == 0) begin
          pause($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end
        send_item(random_item(add_pct, del_pct));
        if (burst_left > 0) burst_left--;
      end
      if (phase == 5) wait_drained();
    end
  endtask

  initial begin
    value_pool = '{32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff,
                   32'sh80000000, 32'sd5, -32'sd7, 32'sd100};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_store();
    test_extremes();
    test_full_store();
    test_random_traffic();
    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && outcomes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
